[src/rgbds_pkg.sv]
// Package for the RGB box-filter downsampler.
// Holds field widths, register indexes, reset values and the controller state type.
// No dependencies.
`default_nettype none

package rgbds_pkg;

    // Pixel channel width and the number of channels in a word
    localparam int DATA_W     = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = DATA_W * NUM_CH;

    // Configuration register widths
    localparam int CFG_W      = 13;
    localparam int BIN_CFG_W  = 5;
    localparam int CFG_IDX_W  = 2;

    // Frame limits and parameter defaults
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_MAX_BIN     = 16;

    // Divider step counter (one quotient bit per step)
    localparam int DIV_CNT_W  = $clog2(DATA_W);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_FACTOR   = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0]     RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0]     RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [BIN_CFG_W-1:0] RST_BIN_FACTOR   = 5'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MOD  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

`default_nettype wire

[src/rgbds_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Used for the per-block-column line store of the downsampler; no package dependency.
`default_nettype none

module rgbds_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/rgb_box_downsample.sv]
// Top level of the RGB box-filter downsampler: frame position tracking, line store
// read-modify-write, bit-serial mean divider and output register.
// Depends on rgbds_pkg and rgbds_ram.
//
// Usage:
//   s_ channel: one RGB pixel per word, raster order, image_width by image_height.
//   m_ channel: one word per whole bin_factor by bin_factor block, carrying the
//     floor mean per channel; m_tlast marks the bottom-right block of the frame.
//   cfg_ port: write image_width (0), image_height (1), bin_factor (2) while idle;
//     every write to one of these restarts the frame at the top-left pixel.
// Flow:
//   A pixel inside a block is accepted, then its line store entry gets the
//     read-modify-write; a pixel outside every whole block is only accepted.
//   A pixel that finishes a block goes through accept, write-back, 8 restoring
//     divide steps and the load of the output register that drives m_tvalid;
//     the input is not ready until the controller is back in idle.
//   The output register frees the input side: the next pixel is accepted while a
//     word waits; the block only holds when a second result is ready before the
//     first is taken.
// Reset: registers return to 640 x 480, bin 2; position restarts at the top left.
//   The line store needs no clearing, the first pixel of a block overwrites its entry.
`default_nettype none

module rgb_box_downsample #(
    parameter int MAX_WIDTH = rgbds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BIN   = rgbds_pkg::DEF_MAX_BIN
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [rgbds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rgbds_pkg::CFG_W-1:0]         cfg_wdata,
    // Pixel input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [rgbds_pkg::PIX_W-1:0]         s_tdata,  // red_in, green_in, blue_in
    // Block mean output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [rgbds_pkg::PIX_W-1:0]         m_tdata,  // red_out, green_out, blue_out
    output logic                                     m_tlast   // frame_last
);

    localparam int DATA_W   = rgbds_pkg::DATA_W;
    localparam int NUM_CH   = rgbds_pkg::NUM_CH;
    localparam int CFG_W    = rgbds_pkg::CFG_W;
    localparam int BCFG_W   = rgbds_pkg::BIN_CFG_W;
    localparam int HLIM     = rgbds_pkg::HEIGHT_LIMIT;
    localparam int CNT_W    = rgbds_pkg::DIV_CNT_W;

    localparam int IDX_W    = $clog2(MAX_WIDTH);
    localparam int COL_W    = $clog2(MAX_WIDTH + 2 * MAX_BIN) + 1;
    localparam int ROW_W    = $clog2(HLIM + 2 * MAX_BIN) + 1;
    localparam int BIN_W    = $clog2(MAX_BIN + 1);
    localparam int PH_W     = $clog2(MAX_BIN);
    localparam int AREA_W   = $clog2(MAX_BIN * MAX_BIN + 1);
    localparam int SUM_W    = $clog2(MAX_BIN * MAX_BIN * 255 + 1);
    localparam int DSH_W    = AREA_W + DATA_W - 1;
    localparam int CMP_W    = (SUM_W > DSH_W) ? SUM_W : DSH_W;
    localparam int WX_W     = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int BX_W     = (BIN_W > BCFG_W) ? BIN_W : BCFG_W;
    localparam int MEM_W    = SUM_W * NUM_CH;

    // Configuration registers
    logic [CFG_W-1:0]  width_reg, width_next;
    logic [CFG_W-1:0]  height_reg, height_next;
    logic [BCFG_W-1:0] bin_reg, bin_next;

    // Frame position
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  cstart_reg, cstart_next;
    logic [PH_W-1:0]   cphase_reg, cphase_next;
    logic [IDX_W-1:0]  bidx_reg, bidx_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]  rstart_reg, rstart_next;
    logic [PH_W-1:0]   rphase_reg, rphase_next;

    // Controller and per-pixel context
    rgbds_pkg::state_t state_reg, state_next;
    logic [NUM_CH-1:0][DATA_W-1:0] pix_reg, pix_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              first_reg, first_next;
    logic              emit_reg, emit_next;
    logic              last_reg, last_next;

    // Divider
    logic [NUM_CH-1:0][SUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_CH-1:0][DATA_W-1:0] quo_reg, quo_next;
    logic [DSH_W-1:0]  dsh_reg, dsh_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [NUM_CH-1:0][DATA_W-1:0] out_reg, out_next;
    logic              out_last_reg, out_last_next;

    // Line store ports
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [NUM_CH-1:0][SUM_W-1:0] ram_wr_data;
    logic [NUM_CH-1:0][SUM_W-1:0] ram_rd_data;

    // Clamped frame geometry
    logic [WX_W-1:0]   width_x;
    logic [BX_W-1:0]   bin_x;
    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  h_row;
    logic [BIN_W-1:0]  bin_c;
    logic [AREA_W-1:0] area;
    logic [COL_W-1:0]  b_col;
    logic [ROW_W-1:0]  b_row;

    // Per-pixel decisions
    logic              accept;
    logic              col_ok;
    logic              row_ok;
    logic              cend;
    logic              rend;
    logic              col_fin;
    logic              row_fin;
    logic              out_free;

    rgbds_ram #(
        .DATA_W (MEM_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (bidx_reg),
        .rd_data (ram_rd_data)
    );

    // Clamp registers to their legal ranges
    always_comb begin
        width_x = WX_W'(width_reg);
        if (width_x == '0) begin
            w_col = COL_W'(1);
        end else if (width_x > WX_W'(MAX_WIDTH)) begin
            w_col = COL_W'(MAX_WIDTH);
        end else begin
            w_col = COL_W'(width_x);
        end

        if (height_reg == '0) begin
            h_row = ROW_W'(1);
        end else if (height_reg > CFG_W'(HLIM)) begin
            h_row = ROW_W'(HLIM);
        end else begin
            h_row = ROW_W'(height_reg);
        end

        bin_x = BX_W'(bin_reg);
        if (bin_x == '0) begin
            bin_c = BIN_W'(1);
        end else if (bin_x > BX_W'(MAX_BIN)) begin
            bin_c = BIN_W'(MAX_BIN);
        end else begin
            bin_c = BIN_W'(bin_x);
        end

        b_col = COL_W'(bin_c);
        b_row = ROW_W'(bin_c);
        area  = AREA_W'(bin_c) * AREA_W'(bin_c);
    end

    // Block membership of the pixel at the current position
    assign col_ok   = (cstart_reg + b_col) <= w_col;
    assign row_ok   = (rstart_reg + b_row) <= h_row;
    assign col_fin  = (cstart_reg + b_col + b_col) > w_col;
    assign row_fin  = (rstart_reg + b_row + b_row) > h_row;
    assign cend     = (BIN_W'(cphase_reg) + BIN_W'(1)) == bin_c;
    assign rend     = (BIN_W'(rphase_reg) + BIN_W'(1)) == bin_c;

    assign s_tready = (state_reg == rgbds_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign ram_rd_en = accept;
    assign ram_wr_en = (state_reg == rgbds_pkg::ST_MOD);

    // Next-state logic
    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        bin_next      = bin_reg;
        col_next      = col_reg;
        cstart_next   = cstart_reg;
        cphase_next   = cphase_reg;
        bidx_next     = bidx_reg;
        row_next      = row_reg;
        rstart_next   = rstart_reg;
        rphase_next   = rphase_reg;
        state_next    = state_reg;
        pix_next      = pix_reg;
        addr_next     = addr_reg;
        first_next    = first_reg;
        emit_next     = emit_reg;
        last_next     = last_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dsh_next      = dsh_reg;
        cnt_next      = cnt_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        m_valid_next  = m_valid_reg;

        // Drop the output word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Sums of the pixel into its line store entry
        for (int c = 0; c < NUM_CH; c++) begin
            if (first_reg) begin
                ram_wr_data[c] = SUM_W'(pix_reg[c]);
            end else begin
                ram_wr_data[c] = ram_rd_data[c] + SUM_W'(pix_reg[c]);
            end
        end

        case (state_reg)
            rgbds_pkg::ST_IDLE: begin
                if (accept) begin
                    pix_next   = s_tdata;
                    addr_next  = bidx_reg;
                    first_next = (cphase_reg == '0) && (rphase_reg == '0);
                    emit_next  = col_ok && row_ok && cend && rend;
                    last_next  = col_fin && row_fin;
                    if (col_ok && row_ok) begin
                        state_next = rgbds_pkg::ST_MOD;
                    end

                    // Advance position inside the row
                    if (cend) begin
                        cphase_next = '0;
                        cstart_next = col_reg + COL_W'(1);
                        bidx_next   = bidx_reg + IDX_W'(1);
                    end else begin
                        cphase_next = cphase_reg + PH_W'(1);
                    end
                    col_next = col_reg + COL_W'(1);

                    // Wrap to the next row, then to the next frame
                    if ((col_reg + COL_W'(1)) >= w_col) begin
                        col_next    = '0;
                        cstart_next = '0;
                        cphase_next = '0;
                        bidx_next   = '0;
                        if (rend) begin
                            rphase_next = '0;
                            rstart_next = row_reg + ROW_W'(1);
                        end else begin
                            rphase_next = rphase_reg + PH_W'(1);
                        end
                        row_next = row_reg + ROW_W'(1);
                        if ((row_reg + ROW_W'(1)) >= h_row) begin
                            row_next    = '0;
                            rstart_next = '0;
                            rphase_next = '0;
                        end
                    end
                end
            end

            rgbds_pkg::ST_MOD: begin
                // Write back the updated sums; start the divide on a finished block
                if (emit_reg) begin
                    rem_next   = ram_wr_data;
                    dsh_next   = DSH_W'(area) << (DATA_W - 1);
                    cnt_next   = '0;
                    state_next = rgbds_pkg::ST_DIV;
                end else begin
                    state_next = rgbds_pkg::ST_IDLE;
                end
            end

            rgbds_pkg::ST_DIV: begin
                // One restoring step per cycle on all channels
                for (int c = 0; c < NUM_CH; c++) begin
                    if (CMP_W'(rem_reg[c]) >= CMP_W'(dsh_reg)) begin
                        rem_next[c] = SUM_W'(CMP_W'(rem_reg[c]) - CMP_W'(dsh_reg));
                        quo_next[c] = {quo_reg[c][DATA_W-2:0], 1'b1};
                    end else begin
                        quo_next[c] = {quo_reg[c][DATA_W-2:0], 1'b0};
                    end
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    state_next = rgbds_pkg::ST_EMIT;
                end
            end

            rgbds_pkg::ST_EMIT: begin
                // Hold until the output register is free
                if (out_free) begin
                    out_next      = quo_reg;
                    out_last_next = last_reg;
                    m_valid_next  = 1'b1;
                    state_next    = rgbds_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rgbds_pkg::ST_IDLE;
            end
        endcase

        // Register writes to a known index restart the frame
        if (cfg_wr_en) begin
            case (cfg_index)
                rgbds_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                rgbds_pkg::REG_IMAGE_HEIGHT: height_next = cfg_wdata;
                rgbds_pkg::REG_BIN_FACTOR:   bin_next    = cfg_wdata[BCFG_W-1:0];
                default: ;
            endcase
            if (cfg_index == rgbds_pkg::REG_IMAGE_WIDTH ||
                cfg_index == rgbds_pkg::REG_IMAGE_HEIGHT ||
                cfg_index == rgbds_pkg::REG_BIN_FACTOR) begin
                col_next    = '0;
                cstart_next = '0;
                cphase_next = '0;
                bidx_next   = '0;
                row_next    = '0;
                rstart_next = '0;
                rphase_next = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= rgbds_pkg::RST_IMAGE_WIDTH;
            height_reg   <= rgbds_pkg::RST_IMAGE_HEIGHT;
            bin_reg      <= rgbds_pkg::RST_BIN_FACTOR;
            col_reg      <= '0;
            cstart_reg   <= '0;
            cphase_reg   <= '0;
            bidx_reg     <= '0;
            row_reg      <= '0;
            rstart_reg   <= '0;
            rphase_reg   <= '0;
            state_reg    <= rgbds_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            bin_reg      <= bin_next;
            col_reg      <= col_next;
            cstart_reg   <= cstart_next;
            cphase_reg   <= cphase_next;
            bidx_reg     <= bidx_next;
            row_reg      <= row_next;
            rstart_reg   <= rstart_next;
            rphase_reg   <= rphase_next;
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pix_reg      <= pix_next;
        addr_reg     <= addr_next;
        first_reg    <= first_next;
        emit_reg     <= emit_next;
        last_reg     <= last_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dsh_reg      <= dsh_next;
        cnt_reg      <= cnt_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[sim/rgb_box_downsample_tb.sv]
`timescale 1ns / 1ps
// Testbench for rgb_box_downsample: a directed table, fixed corner phases and random frames
// over many register settings; every output word is checked against the table's mean or a box-filter model.
// Depends on rgbds_pkg and the rgb_box_downsample RTL.

module rgb_box_downsample_tb;

    localparam int DATA_W        = rgbds_pkg::DATA_W;
    localparam int PIX_W         = rgbds_pkg::PIX_W;
    localparam int CFG_W         = rgbds_pkg::CFG_W;
    localparam int CFG_IDX_W     = rgbds_pkg::CFG_IDX_W;
    localparam int BIN_CFG_W     = rgbds_pkg::BIN_CFG_W;
    localparam int DEF_MAX_WIDTH = rgbds_pkg::DEF_MAX_WIDTH;
    localparam int DEF_MAX_BIN   = rgbds_pkg::DEF_MAX_BIN;
    localparam int HEIGHT_LIMIT  = rgbds_pkg::HEIGHT_LIMIT;

    localparam int LINE_DEPTH   = DEF_MAX_WIDTH;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 120;
    localparam int RANDOM_WORDS = 40;
    // index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] red;
        logic [DATA_W-1:0] green;
        logic [DATA_W-1:0] blue;
        logic              last;
    } block_mean_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      value;
        logic [PIX_W-1:0]      pixel;
        logic                  typed;
        block_mean_t           mean;
    } script_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tlast;

    rgb_box_downsample u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Generous run limit
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Model state: registers, frame position and per-block-column channel sums
    logic [CFG_W-1:0]     reg_width  = rgbds_pkg::RST_IMAGE_WIDTH;
    logic [CFG_W-1:0]     reg_height = rgbds_pkg::RST_IMAGE_HEIGHT;
    logic [BIN_CFG_W-1:0] reg_bin    = rgbds_pkg::RST_BIN_FACTOR;
    int unsigned col_pos = 0, row_pos = 0, col_ph = 0, row_ph = 0, blk = 0;
    logic [15:0] acc_red   [LINE_DEPTH];
    logic [15:0] acc_green [LINE_DEPTH];
    logic [15:0] acc_blue  [LINE_DEPTH];

    block_mean_t mean_q[$];
    int          mismatches = 0;
    int          words_seen = 0;
    int          hold_reqs  = 0;
    bit          idle_on    = 1'b0;

    function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(4) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] px;
        px = PIX_W'($urandom);
        if ($urandom_range(7) == 0) px = ($urandom_range(1) != 0) ? '1 : '0;
        return px;
    endfunction

    // Accumulate one pixel into its block; report the block mean when the block closes
    task automatic bin_pixel(input logic [PIX_W-1:0] px, output bit in_block, output bit made,
                             output block_mean_t res);
        int unsigned w, h, bf, bx, by, area;
        bit first;
        w  = clampv(reg_width, 1, DEF_MAX_WIDTH);
        h  = clampv(reg_height, 1, HEIGHT_LIMIT);
        bf = clampv(reg_bin, 1, DEF_MAX_BIN);
        bx = w / bf;
        by = h / bf;
        in_block = 1'b0;
        made     = 1'b0;
        res      = '0;
        if (col_pos < bx * bf && row_pos < by * bf) begin
            in_block = 1'b1;
            first    = (row_ph == 0 && col_ph == 0);
            acc_red[blk]   = first ? 16'(px[7:0])   : acc_red[blk]   + px[7:0];
            acc_green[blk] = first ? 16'(px[15:8])  : acc_green[blk] + px[15:8];
            acc_blue[blk]  = first ? 16'(px[23:16]) : acc_blue[blk]  + px[23:16];
            if (row_ph + 1 >= bf && col_ph + 1 >= bf) begin
                area      = bf * bf;
                res.red   = DATA_W'(acc_red[blk] / area);
                res.green = DATA_W'(acc_green[blk] / area);
                res.blue  = DATA_W'(acc_blue[blk] / area);
                res.last  = (blk + 1 == bx && row_pos + 1 == by * bf);
                made      = 1'b1;
            end
        end
        // advance to the next pixel position
        if (col_ph + 1 >= bf) begin
            col_ph = 0;
            blk++;
        end else begin
            col_ph++;
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            col_ph  = 0;
            blk     = 0;
            if (row_ph + 1 >= bf) row_ph = 0;
            else row_ph++;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
                row_ph  = 0;
            end
        end
    endtask

    // Offer one pixel word, hold it until taken, then log its expected mean
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input block_mean_t typed_mean, output bit in_block);
        int unsigned gap;
        bit made;
        block_mean_t res;
        gap = (idle_on && $urandom_range(3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        bin_pixel(px, in_block, made, res);
        if (typed) mean_q.push_back(typed_mean);
        else if (made) mean_q.push_back(res);
    endtask

    // Stop offering, wait for every expected word, then let the pipeline drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (mean_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        bit known;
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // mirror the write; a known register restarts the frame
        known = 1'b1;
        case (idx)
            rgbds_pkg::REG_IMAGE_WIDTH:  reg_width  = value;
            rgbds_pkg::REG_IMAGE_HEIGHT: reg_height = value;
            rgbds_pkg::REG_BIN_FACTOR:   reg_bin    = value[BIN_CFG_W-1:0];
            default:                     known      = 1'b0;
        endcase
        if (known) begin
            col_pos = 0;
            row_pos = 0;
            col_ph  = 0;
            row_ph  = 0;
            blk     = 0;
        end
    endtask

    function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.value = value;
        return row;
    endfunction

    function automatic script_row_t pix_row(logic [PIX_W-1:0] px, logic typed, block_mean_t mean);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_PIX;
        row.pixel = px;
        row.typed = typed;
        row.mean  = mean;
        return row;
    endfunction

    // Output side: check each taken word, then pick the next ready level
    int unsigned hold_left = 0, hold_done = 0, ready_gap = 0;
    always @(posedge aclk) begin : result_side
        block_mean_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
            words_seen++;
            if (mean_q.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected word, expected none, got r=%h g=%h b=%h last=%b",
                         $time, got.red, got.green, got.blue, got.last);
            end else begin
                want = mean_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.last !== want.last) begin
                    mismatches++;
                    $display({"%0t ns: mean mismatch, expected r=%h g=%h b=%h last=%b,",
                              " got r=%h g=%h b=%h last=%b"}, $time,
                             want.red, want.green, want.blue, want.last,
                             got.red, got.green, got.blue, got.last);
                end
            end
        end
        if (hold_done != hold_reqs) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(3) == 0) ready_gap = pick_gap();
        end
    end

    initial begin : stimulus
        script_row_t script[$];
        script_row_t row;
        block_mean_t none;
        bit in_block;
        int unsigned w, h, nframes, npix, sel, rand_sent;

        none      = '0;
        rand_sent = 0;

        // Directed table: pass-through, extremes, floor, clamps, ignored index
        script.push_back(cfg_row(rgbds_pkg::REG_IMAGE_WIDTH, 13'd2));
        script.push_back(cfg_row(rgbds_pkg::REG_IMAGE_HEIGHT, 13'd2));
        script.push_back(cfg_row(rgbds_pkg::REG_BIN_FACTOR, 13'd1));
        script.push_back(pix_row(24'h000000, 1'b1, {8'h00, 8'h00, 8'h00, 1'b0}));
        script.push_back(pix_row(24'hFFFFFF, 1'b1, {8'hFF, 8'hFF, 8'hFF, 1'b0}));
        script.push_back(pix_row(24'h0FAA55, 1'b1, {8'h55, 8'hAA, 8'h0F, 1'b0}));
        script.push_back(pix_row(24'hF055AA, 1'b1, {8'hAA, 8'h55, 8'hF0, 1'b1}));
        script.push_back(cfg_row(rgbds_pkg::REG_BIN_FACTOR, 13'd2));
        script.push_back(pix_row(24'hFFFFFF, 1'b0, none));
        script.push_back(pix_row(24'hFFFFFF, 1'b0, none));
        script.push_back(pix_row(24'hFFFFFF, 1'b0, none));
        script.push_back(pix_row(24'hFFFFFF, 1'b1, {8'hFF, 8'hFF, 8'hFF, 1'b1}));
        // sums that are not a multiple of four round down
        script.push_back(pix_row(24'hFF0103, 1'b0, none));
        script.push_back(pix_row(24'hFE0000, 1'b0, none));
        script.push_back(pix_row(24'hFF0200, 1'b0, none));
        script.push_back(pix_row(24'hFF0000, 1'b0, none));
        // bin zero reads as one
        script.push_back(cfg_row(rgbds_pkg::REG_BIN_FACTOR, 13'd0));
        script.push_back(pix_row(24'h090807, 1'b1, {8'h07, 8'h08, 8'h09, 1'b0}));
        // unused index neither changes a register nor restarts the frame
        script.push_back(cfg_row(REG_UNUSED, 13'h1FFF));
        script.push_back(pix_row(24'h0C0B0A, 1'b1, {8'h0A, 8'h0B, 8'h0C, 1'b0}));
        // zero size clamps to one, bin clamps to its maximum: no whole block
        script.push_back(cfg_row(rgbds_pkg::REG_IMAGE_WIDTH, 13'd0));
        script.push_back(cfg_row(rgbds_pkg::REG_IMAGE_HEIGHT, 13'd0));
        script.push_back(cfg_row(rgbds_pkg::REG_BIN_FACTOR, 13'd31));
        script.push_back(pix_row(24'h123456, 1'b0, none));
        script.push_back(pix_row(24'hEDCBA9, 1'b0, none));
        script.push_back(cfg_row(rgbds_pkg::REG_BIN_FACTOR, 13'd1));
        script.push_back(pix_row(24'h3264C8, 1'b1, {8'hC8, 8'h64, 8'h32, 1'b1}));
        script.push_back(pix_row(24'hFFFFFF, 1'b1, {8'hFF, 8'hFF, 8'hFF, 1'b1}));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset height and bin: narrow rows of 2x2 blocks, none of them the last
        cfg_write(rgbds_pkg::REG_IMAGE_WIDTH, 13'd4);
        repeat (8) send_pixel(rand_pixel(), 1'b0, none, in_block);

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                cfg_write(row.idx, row.value);
            end else begin
                send_pixel(row.pixel, row.typed, row.mean, in_block);
            end
        end

        // Hold the output off while every pixel makes a word, so the input backs up
        wait_idle();
        cfg_write(rgbds_pkg::REG_IMAGE_WIDTH, 13'd8);
        cfg_write(rgbds_pkg::REG_IMAGE_HEIGHT, 13'd8);
        hold_reqs++;
        repeat (64) send_pixel(rand_pixel(), 1'b0, none, in_block);

        // Largest bin, with a spare column dropped on the right
        wait_idle();
        idle_on = 1'b1;
        cfg_write(rgbds_pkg::REG_IMAGE_WIDTH, 13'd17);
        cfg_write(rgbds_pkg::REG_IMAGE_HEIGHT, 13'd16);
        cfg_write(rgbds_pkg::REG_BIN_FACTOR, 13'd16);
        repeat (17 * 16) send_pixel(rand_pixel(), 1'b0, none, in_block);

        // Random settings, mostly whole frames, some cut short
        while (rand_sent < RANDOM_ITEMS || words_seen < RANDOM_WORDS) begin
            wait_idle();
            idle_on = ($urandom_range(4) != 0);
            w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
            cfg_write(rgbds_pkg::REG_IMAGE_WIDTH, CFG_W'(w));
            cfg_write(rgbds_pkg::REG_IMAGE_HEIGHT, CFG_W'(h));
            if ($urandom_range(3) != 0) begin
                sel = $urandom_range(9);
                if (sel <= 6)
                    cfg_write(rgbds_pkg::REG_BIN_FACTOR, CFG_W'($urandom_range(1, 4)));
                else if (sel == 7)
                    cfg_write(rgbds_pkg::REG_BIN_FACTOR, 13'd0);
                else if (sel == 8)
                    cfg_write(rgbds_pkg::REG_BIN_FACTOR, CFG_W'($urandom_range(5, 8)));
                else
                    cfg_write(rgbds_pkg::REG_BIN_FACTOR, CFG_W'($urandom_range(17, 31)));
            end
            if ($urandom_range(7) == 0) cfg_write(REG_UNUSED, CFG_W'($urandom));
            w = clampv(reg_width, 1, DEF_MAX_WIDTH);
            h = clampv(reg_height, 1, HEIGHT_LIMIT);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                npix = ($urandom_range(5) == 0) ? $urandom_range(1, w * h) : w * h;
                repeat (npix) begin
                    send_pixel(rand_pixel(), 1'b0, none, in_block);
                    rand_sent += in_block;
                end
                if (npix != w * h) break;
            end
        end

        // Drain and report
        s_tvalid <= 1'b0;
        while (mean_q.size() != 0) @(posedge aclk);
        repeat (2 * DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
src/rgbds_pkg.sv
src/rgbds_ram.sv
src/rgb_box_downsample.sv
sim/rgb_box_downsample_tb.sv
